// File: hdl/lcdrf_pkg.sv
// Shared constants, address map, register offsets and port structs for the LCD register file.
`timescale 1ns / 1ps
package lcdrf_pkg;

  localparam int DEF_VRAM_BANK_BYTES = 8192;
  localparam int DEF_VRAM_BANKS      = 2;
  localparam int DEF_OAM_BYTES       = 160;
  localparam int DEF_PALETTE_BYTES   = 64;

  // Fixed by the 8 KiB bank window of the CPU map.
  localparam int VRAM_OFF_W = 13;

  localparam logic [15:0] ADDR_VRAM_LO = 16'h8000;
  localparam logic [15:0] ADDR_VRAM_HI = 16'h9fff;
  localparam logic [15:0] ADDR_OAM_LO  = 16'hfe00;
  localparam logic [15:0] ADDR_OAM_HI  = 16'hfe9f;
  localparam logic [15:0] ADDR_IO_LO   = 16'hff40;
  localparam logic [15:0] ADDR_IO_HI   = 16'hff7f;

  localparam logic [7:0] REG_LCDC = 8'h40;
  localparam logic [7:0] REG_STAT = 8'h41;
  localparam logic [7:0] REG_SCY  = 8'h42;
  localparam logic [7:0] REG_SCX  = 8'h43;
  localparam logic [7:0] REG_LY   = 8'h44;
  localparam logic [7:0] REG_LYC  = 8'h45;
  localparam logic [7:0] REG_DMA  = 8'h46;
  localparam logic [7:0] REG_BGP  = 8'h47;
  localparam logic [7:0] REG_OBP0 = 8'h48;
  localparam logic [7:0] REG_OBP1 = 8'h49;
  localparam logic [7:0] REG_WY   = 8'h4a;
  localparam logic [7:0] REG_WX   = 8'h4b;
  localparam logic [7:0] REG_VBK  = 8'h4f;
  localparam logic [7:0] REG_BGPI = 8'h68;
  localparam logic [7:0] REG_BGPD = 8'h69;
  localparam logic [7:0] REG_OBPI = 8'h6a;
  localparam logic [7:0] REG_OBPD = 8'h6b;

  localparam logic [2:0] PHASE_DATA = 3'd2;
  localparam logic [2:0] PHASE_CTRL = 3'd4;

  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [1:0] {
    RGN_NONE,
    RGN_VRAM,
    RGN_OAM,
    RGN_IO
  } lcdrf_region_t;

  typedef struct packed {
    lcdrf_region_t             region;
    logic [7:0]                low;
    logic [VRAM_OFF_W-1:0]     vram_off;
  } lcdrf_dec_t;

  typedef struct packed {
    logic       vram_we;
    logic       oam_we;
    logic       bgp_we;
    logic       obp_we;
    logic [7:0] data;
  } lcdrf_wr_t;

  typedef struct packed {
    logic [7:0] vram;
    logic [7:0] oam;
    logic [7:0] bgp;
    logic [7:0] obp;
  } lcdrf_rd_t;

endpackage

// File: hdl/lcdrf_decode.sv
// CPU address decode into memory region and register offset.
`timescale 1ns / 1ps
module lcdrf_decode import lcdrf_pkg::*; #(
  parameter int OAM_BYTES = DEF_OAM_BYTES
) (
  input  logic [15:0] bus_address,
  output lcdrf_dec_t  dec
);

  always_comb begin
    dec.low      = bus_address[7:0];
    dec.vram_off = bus_address[VRAM_OFF_W-1:0];
    if (bus_address >= ADDR_VRAM_LO && bus_address <= ADDR_VRAM_HI) begin
      dec.region = RGN_VRAM;
    end else if (bus_address >= ADDR_OAM_LO && bus_address <= ADDR_OAM_HI) begin
      // past the end of sprite RAM behaves as unmapped
      dec.region = ({1'b0, bus_address[7:0]} < 9'(OAM_BYTES)) ? RGN_OAM : RGN_NONE;
    end else if (bus_address >= ADDR_IO_LO && bus_address <= ADDR_IO_HI) begin
      dec.region = RGN_IO;
    end else begin
      dec.region = RGN_NONE;
    end
  end

endmodule

// File: hdl/lcdrf_mem.sv
// Video, sprite and palette memories with registered reads and a clearing pass after reset.
`timescale 1ns / 1ps
module lcdrf_mem import lcdrf_pkg::*; #(
  parameter int VRAM_BANK_BYTES = DEF_VRAM_BANK_BYTES,
  parameter int VRAM_BANKS      = DEF_VRAM_BANKS,
  parameter int OAM_BYTES       = DEF_OAM_BYTES,
  parameter int PALETTE_BYTES   = DEF_PALETTE_BYTES,
  localparam int VRAM_DEPTH     = VRAM_BANKS * VRAM_BANK_BYTES,
  localparam int VA_W           = $clog2(VRAM_DEPTH),
  localparam int OA_W           = $clog2(OAM_BYTES),
  localparam int PA_W           = $clog2(PALETTE_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            acc,
  input  logic [VA_W-1:0] vram_addr,
  input  logic [OA_W-1:0] oam_addr,
  input  logic [PA_W-1:0] bgp_addr,
  input  logic [PA_W-1:0] obp_addr,
  input  lcdrf_wr_t       wr,
  output lcdrf_rd_t       rd,
  output logic            clearing
);

  logic [7:0] vram [VRAM_DEPTH];
  logic [7:0] oam  [OAM_BYTES];
  logic [7:0] bgp  [PALETTE_BYTES];
  logic [7:0] obp  [PALETTE_BYTES];

  logic [VA_W-1:0] clr_addr;
  logic [VA_W-1:0] vram_aq;
  logic [OA_W-1:0] oam_aq;
  logic [PA_W-1:0] bgp_aq;
  logic [PA_W-1:0] obp_aq;

  logic [7:0] vram_q, oam_q, bgp_q, obp_q;

  assign rd = '{vram: vram_q, oam: oam_q, bgp: bgp_q, obp: obp_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == VA_W'(VRAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // hold the item's addresses for the write-back cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      vram_aq <= vram_addr;
      oam_aq  <= oam_addr;
      bgp_aq  <= bgp_addr;
      obp_aq  <= obp_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      vram[clr_addr] <= '0;
    end else if (wr.vram_we) begin
      vram[vram_aq] <= wr.data;
    end
    if (acc) begin
      vram_q <= vram[vram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_addr < VA_W'(OAM_BYTES)) begin
        oam[clr_addr[OA_W-1:0]] <= '0;
      end
    end else if (wr.oam_we) begin
      oam[oam_aq] <= wr.data;
    end
    if (acc) begin
      oam_q <= oam[oam_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_addr < VA_W'(PALETTE_BYTES)) begin
        bgp[clr_addr[PA_W-1:0]] <= '0;
      end
    end else if (wr.bgp_we) begin
      bgp[bgp_aq] <= wr.data;
    end
    if (acc) begin
      bgp_q <= bgp[bgp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_addr < VA_W'(PALETTE_BYTES)) begin
        obp[clr_addr[PA_W-1:0]] <= '0;
      end
    end else if (wr.obp_we) begin
      obp[obp_aq] <= wr.data;
    end
    if (acc) begin
      obp_q <= obp[obp_addr];
    end
  end

endmodule

// File: hdl/lcd_controller_register_file_unit.sv
// Top level of the LCD controller bus register file: control FSM, I/O registers, result strobe.
`timescale 1ns / 1ps
// One CPU bus access is one item: it is accepted at a rising edge with start high and busy
// low, and its result appears on read_data and the pulse outputs for exactly one cycle with
// done high, registered from the execute state; results cannot be held off. Busy stays high
// through the execute state, so no new item is taken before the last is through: first the
// registered read of the video, sprite and palette memories, then the execute state decides
// the access and writes back. After reset the block clears all memories, one entry a cycle,
// VRAM_BANKS * VRAM_BANK_BYTES entries (16384 by default), with busy high; colour_mode writes
// through cfg_we/cfg_data are taken at any time. dma_page always shows the stored page.
module lcd_controller_register_file_unit import lcdrf_pkg::*; #(
  parameter int VRAM_BANK_BYTES = DEF_VRAM_BANK_BYTES,
  parameter int VRAM_BANKS      = DEF_VRAM_BANKS,
  parameter int OAM_BYTES       = DEF_OAM_BYTES,
  parameter int PALETTE_BYTES   = DEF_PALETTE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [2:0]  bus_phase,
  input  logic [15:0] bus_address,
  input  logic [7:0]  bus_data,
  input  logic        vram_open,
  input  logic        oam_open,
  input  logic [1:0]  mode_delayed,
  input  logic        line_match,
  input  logic [7:0]  current_line,
  input  logic        oam_copy_busy,
  output logic        done,
  output logic [7:0]  read_data,
  output logic        frame_restart,
  output logic        display_latch_set,
  output logic        line_reset,
  output logic        dma_start,
  output logic [7:0]  dma_page
);

  localparam int VA_W = $clog2(VRAM_BANKS * VRAM_BANK_BYTES);
  localparam int OA_W = $clog2(OAM_BYTES);
  localparam int PA_W = $clog2(PALETTE_BYTES);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  logic   clearing;
  logic   acc;

  // configuration and register state
  logic       colour_mode;
  logic [7:0] lcd_control;
  logic [3:0] irq_enables;
  logic [7:0] scroll_y, scroll_x, line_compare, window_y, window_x;
  logic [7:0] dma_source;
  logic [7:0] bg_shades, obj_shades0, obj_shades1;
  logic       vram_bank_sel;
  logic [5:0] bg_idx, obj_idx;
  logic       bg_inc, obj_inc;

  // item held for the execute cycle
  lcdrf_dec_t dec, dec_q;
  logic       func_q, vopen_q, oopen_q, match_q, copy_busy_q;
  logic [2:0] phase_q;
  logic [7:0] data_q, line_q;
  logic [1:0] mode_q;

  lcdrf_wr_t  wr;
  lcdrf_rd_t  rd;
  logic       bank_eff;

  // results of the execute cycle
  logic [7:0] rd_val;
  logic       restart_val, latch_val, lreset_val, dstart_val;
  logic       ph_data, ph_ctrl, is_wr;

  assign busy     = clearing || (state == S_EXEC);
  assign acc      = start && !busy;
  assign dma_page = dma_source;
  assign bank_eff = (VRAM_BANKS > 1) ? vram_bank_sel : 1'b0;

  lcdrf_decode #(
    .OAM_BYTES(OAM_BYTES)
  ) u_decode (
    .bus_address(bus_address),
    .dec        (dec)
  );

  // Read addresses come from the live bus so the data is ready in the execute cycle;
  // palette indexes only move at write-back, so they are stable here.
  lcdrf_mem #(
    .VRAM_BANK_BYTES(VRAM_BANK_BYTES),
    .VRAM_BANKS     (VRAM_BANKS),
    .OAM_BYTES      (OAM_BYTES),
    .PALETTE_BYTES  (PALETTE_BYTES)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .vram_addr(VA_W'({bank_eff, dec.vram_off})),
    .oam_addr (dec.low[OA_W-1:0]),
    .bgp_addr (bg_idx[PA_W-1:0]),
    .obp_addr (obj_idx[PA_W-1:0]),
    .wr       (wr),
    .rd       (rd),
    .clearing (clearing)
  );

  // Capture the item.
  always_ff @(posedge clk) begin
    if (acc) begin
      dec_q       <= dec;
      func_q      <= func;
      phase_q     <= bus_phase;
      data_q      <= bus_data;
      vopen_q     <= vram_open;
      oopen_q     <= oam_open;
      mode_q      <= mode_delayed;
      match_q     <= line_match;
      line_q      <= current_line;
      copy_busy_q <= oam_copy_busy;
    end
  end

  assign ph_data = (phase_q == PHASE_DATA);
  assign ph_ctrl = (phase_q == PHASE_CTRL);
  assign is_wr   = (func_q == FUNC_WRITE);

  // Decide the access: read value, pulses and memory write enables.
  always_comb begin
    rd_val      = data_q;
    restart_val = 1'b0;
    latch_val   = 1'b0;
    lreset_val  = 1'b0;
    dstart_val  = 1'b0;
    wr          = '0;
    wr.data     = data_q;
    case (dec_q.region)
      RGN_VRAM: begin
        if (ph_data) begin
          if (is_wr) begin
            wr.vram_we = 1'b1;
          end else if (vopen_q) begin
            rd_val = rd.vram;
          end
        end
      end
      RGN_OAM: begin
        if (ph_data) begin
          if (is_wr) begin
            // drop CPU writes while the sprite copy owns the RAM
            wr.oam_we = !copy_busy_q;
          end else if (oopen_q) begin
            rd_val = rd.oam;
          end
        end
      end
      RGN_IO: begin
        if (is_wr) begin
          if (dec_q.low == REG_LCDC) begin
            if (ph_ctrl && (lcd_control[7] != data_q[7])) begin
              restart_val = 1'b1;
              latch_val   = data_q[7];
            end
          end else if (ph_data) begin
            case (dec_q.low)
              REG_LY:   lreset_val = 1'b1;
              REG_DMA:  dstart_val = 1'b1;
              REG_BGPD: wr.bgp_we  = colour_mode;
              REG_OBPD: wr.obp_we  = colour_mode;
              default:  ;
            endcase
          end
        end else if (ph_data) begin
          case (dec_q.low)
            REG_LCDC: rd_val = lcd_control;
            REG_STAT: rd_val = {1'b1, irq_enables, match_q, mode_q};
            REG_SCY:  rd_val = scroll_y;
            REG_SCX:  rd_val = scroll_x;
            REG_LY:   rd_val = line_q;
            REG_LYC:  rd_val = line_compare;
            REG_DMA:  rd_val = dma_source;
            REG_BGP:  rd_val = bg_shades;
            REG_OBP0: rd_val = obj_shades0;
            REG_OBP1: rd_val = obj_shades1;
            REG_WY:   rd_val = window_y;
            REG_WX:   rd_val = window_x;
            REG_VBK:  if (colour_mode) rd_val = {7'b0, vram_bank_sel};
            REG_BGPI: if (colour_mode) rd_val = {bg_inc, data_q[6], bg_idx};
            REG_BGPD: if (colour_mode) rd_val = rd.bgp;
            REG_OBPI: if (colour_mode) rd_val = {obj_inc, data_q[6], obj_idx};
            REG_OBPD: if (colour_mode) rd_val = rd.obp;
            default:  ;
          endcase
        end
      end
      default: ;
    endcase
    // only the execute cycle may write the memories
    if (state != S_EXEC) begin
      wr.vram_we = 1'b0;
      wr.oam_we  = 1'b0;
      wr.bgp_we  = 1'b0;
      wr.obp_we  = 1'b0;
    end
  end

  // Sequencer and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      done              <= 1'b0;
      frame_restart     <= 1'b0;
      display_latch_set <= 1'b0;
      line_reset        <= 1'b0;
      dma_start         <= 1'b0;
    end else begin
      done              <= (state == S_EXEC);
      frame_restart     <= (state == S_EXEC) && restart_val;
      display_latch_set <= (state == S_EXEC) && latch_val;
      line_reset        <= (state == S_EXEC) && lreset_val;
      dma_start         <= (state == S_EXEC) && dstart_val;
      case (state)
        S_IDLE:  if (acc) state <= S_EXEC;
        S_EXEC:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      read_data <= rd_val;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_mode <= 1'b0;
    end else if (cfg_we) begin
      colour_mode <= cfg_data;
    end
  end

  // Register write-back at the end of the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control   <= '0;
      irq_enables   <= '0;
      scroll_y      <= '0;
      scroll_x      <= '0;
      line_compare  <= '0;
      window_y      <= '0;
      window_x      <= '0;
      dma_source    <= '0;
      bg_shades     <= '0;
      obj_shades0   <= '0;
      obj_shades1   <= '0;
      vram_bank_sel <= 1'b0;
      bg_idx        <= '0;
      bg_inc        <= 1'b0;
      obj_idx       <= '0;
      obj_inc       <= 1'b0;
    end else if (state == S_EXEC && is_wr && dec_q.region == RGN_IO) begin
      if (dec_q.low == REG_LCDC) begin
        if (ph_ctrl) lcd_control <= data_q;
      end else if (dec_q.low == REG_STAT) begin
        // mono mode: a data-phase write forces every interrupt enable on
        if (ph_data && !colour_mode) begin
          irq_enables <= 4'hf;
        end else if (ph_ctrl) begin
          irq_enables <= data_q[6:3];
        end
      end else if (ph_data) begin
        case (dec_q.low)
          REG_SCY:  scroll_y     <= data_q;
          REG_SCX:  scroll_x     <= data_q;
          REG_LYC:  line_compare <= data_q;
          REG_DMA:  dma_source   <= data_q;
          REG_BGP:  bg_shades    <= data_q;
          REG_OBP0: obj_shades0  <= data_q;
          REG_OBP1: obj_shades1  <= data_q;
          REG_WY:   window_y     <= data_q;
          REG_WX:   window_x     <= data_q;
          REG_VBK:  if (colour_mode) vram_bank_sel <= data_q[0];
          REG_BGPI: begin
            if (colour_mode) begin
              bg_idx <= data_q[5:0];
              bg_inc <= data_q[7];
            end
          end
          REG_BGPD: if (colour_mode && bg_inc) bg_idx <= bg_idx + 6'd1;
          REG_OBPI: begin
            if (colour_mode) begin
              obj_idx <= data_q[5:0];
              obj_inc <= data_q[7];
            end
          end
          REG_OBPD: if (colour_mode && obj_inc) obj_idx <= obj_idx + 6'd1;
          default:  ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result strobe");

  a_done_from_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_pulses_with_done: assert property (@(posedge clk) disable iff (rst)
    (frame_restart || line_reset || dma_start) |-> done)
    else $error("event pulse outside a result cycle");

  a_latch_needs_restart: assert property (@(posedge clk) disable iff (rst)
    display_latch_set |-> frame_restart)
    else $error("display latch set without a frame restart");
`endif

endmodule
